FILE: hdl/rits_pkg.sv
`timescale 1ns / 1ps
// Package: codes, widths and structs shared by the table sequencer modules.
package rits_pkg;

    localparam int unsigned MODE_W   = 4;
    localparam int unsigned OFFS_W   = 32;
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned ACTION_W = 3;
    localparam int unsigned USEC_W   = 32;
    localparam int unsigned SKIP_W   = 32;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned CFG_IDX_W = 1;

    typedef logic [MODE_W-1:0]    mode_t;
    typedef logic [ACTION_W-1:0]  action_t;
    typedef logic [KIND_W-1:0]    kind_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Table entry operation codes
    localparam mode_t MODE_ACCESS      = 4'd0;
    localparam mode_t MODE_SWITCHMODE  = 4'd1;
    localparam mode_t MODE_NOP         = 4'd2;
    localparam mode_t MODE_DELAY       = 4'd3;
    localparam mode_t MODE_MODIFYSTORE = 4'd4;
    localparam mode_t MODE_IFEQUAL     = 4'd5;
    localparam mode_t MODE_IFRANGE     = 4'd6;
    localparam mode_t MODE_EQUALSKIPN  = 4'd7;
    localparam mode_t MODE_TABLESTART  = 4'd8;

    // Result action codes
    localparam action_t ACT_NONE  = 3'd0;
    localparam action_t ACT_WRITE = 3'd1;
    localparam action_t ACT_READ  = 3'd2;
    localparam action_t ACT_DELAY = 3'd3;
    localparam action_t ACT_ERROR = 3'd4;

    // Access kinds
    localparam kind_t KIND_READ  = 2'd0;
    localparam kind_t KIND_WRITE = 2'd1;
    localparam kind_t KIND_RMW   = 2'd2;

    // Configuration register indexes
    localparam cfg_idx_t CFG_ADDR_BASE        = 1'd0;
    localparam cfg_idx_t CFG_NARROW_REGISTERS = 1'd1;

    typedef struct packed {
        mode_t              mode;
        logic [OFFS_W-1:0]  entry_offset;
        logic [WORD_W-1:0]  entry_mask;
        logic [WORD_W-1:0]  entry_value;
        logic [WORD_W-1:0]  current_contents;
    } item_t;

    typedef struct packed {
        action_t            action;
        logic [WORD_W-1:0]  write_address;
        logic [WORD_W-1:0]  write_data;
        logic [USEC_W-1:0]  delay_usec;
        logic               was_skipped;
    } result_t;

    typedef struct packed {
        logic [WORD_W-1:0]  buffer_value;
        logic               store_next_flag;
        logic [SKIP_W-1:0]  skip_remaining;
        kind_t              access_kind;
    } seq_state_t;

    typedef struct packed {
        logic [WORD_W-1:0]  addr_base;
        logic               narrow_registers;
    } cfg_t;

    localparam seq_state_t STATE_RESET = '{
        buffer_value:    '0,
        store_next_flag: 1'b0,
        skip_remaining:  '0,
        access_kind:     KIND_RMW
    };

endpackage

FILE: hdl/rits_if.sv
`timescale 1ns / 1ps
// Interfaces: table entry channel, result channel and configuration write channel.
interface rits_item_if
    import rits_pkg::*;
;
    logic               valid;
    logic               ready;
    mode_t              mode;
    logic [OFFS_W-1:0]  entry_offset;
    logic [WORD_W-1:0]  entry_mask;
    logic [WORD_W-1:0]  entry_value;
    logic [WORD_W-1:0]  current_contents;

    modport source (output valid, mode, entry_offset, entry_mask, entry_value,
                    current_contents, input ready);
    modport sink   (input valid, mode, entry_offset, entry_mask, entry_value,
                    current_contents, output ready);
endinterface

interface rits_result_if
    import rits_pkg::*;
;
    logic               valid;
    logic               ready;
    action_t            action;
    logic [WORD_W-1:0]  write_address;
    logic [WORD_W-1:0]  write_data;
    logic [USEC_W-1:0]  delay_usec;
    logic               was_skipped;

    modport source (output valid, action, write_address, write_data, delay_usec,
                    was_skipped, input ready);
    modport sink   (input valid, action, write_address, write_data, delay_usec,
                    was_skipped, output ready);
endinterface

interface rits_cfg_if
    import rits_pkg::*;
;
    logic               valid;
    logic               ready;
    cfg_idx_t           index;
    logic [WORD_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/rits_exec.sv
`timescale 1ns / 1ps
// Entry execution logic: one table entry against the running state.
module rits_exec
    import rits_pkg::*;
(
    input  item_t      item,
    input  seq_state_t state,
    input  cfg_t       cfg,
    output result_t    result,
    output seq_state_t state_next
);

    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] value;
    logic [WORD_W-1:0] contents;
    logic [WORD_W-1:0] loaded;
    logic [WORD_W-1:0] hi_keep;

    // Narrow registers: keep only the low half of the mask, value and contents operands
    assign hi_keep  = cfg.narrow_registers ? {{(WORD_W-32){1'b0}}, {32{1'b1}}} : '1;
    assign mask     = item.entry_mask & hi_keep;
    assign value    = item.entry_value & hi_keep;
    assign contents = item.current_contents & hi_keep;

    always_comb
    begin
        state_next = state;
        result     = '0;
        loaded     = '0;

        if (item.mode == MODE_TABLESTART)
        begin
            state_next = STATE_RESET;
        end
        else if (state.skip_remaining != '0)
        begin
            state_next.skip_remaining = state.skip_remaining - SKIP_W'(1);
            result.was_skipped        = 1'b1;
        end
        else
        begin
            case (item.mode)
                MODE_ACCESS:
                begin
                    result.write_address = cfg.addr_base
                                         + {{(WORD_W-OFFS_W){1'b0}}, item.entry_offset};
                    if (state.access_kind == KIND_WRITE)
                        loaded = value & ~mask;
                    else
                        loaded = (contents & ~mask) | value;
                    if (!state.store_next_flag)
                        state_next.buffer_value = loaded;
                    state_next.store_next_flag = 1'b0;
                    if (state.access_kind == KIND_READ)
                    begin
                        result.action = ACT_READ;
                    end
                    else
                    begin
                        result.action     = ACT_WRITE;
                        result.write_data = state_next.buffer_value & hi_keep;
                    end
                end
                MODE_SWITCHMODE:
                begin
                    if (mask <= WORD_W'(KIND_RMW))
                        state_next.access_kind = mask[KIND_W-1:0];
                    else
                        result.action = ACT_ERROR;
                end
                MODE_NOP:
                begin
                end
                MODE_DELAY:
                begin
                    result.action     = ACT_DELAY;
                    result.delay_usec = mask[USEC_W-1:0];
                end
                MODE_MODIFYSTORE:
                begin
                    state_next.buffer_value    = (state.buffer_value & ~mask) | value;
                    state_next.store_next_flag = 1'b1;
                    if (state.access_kind == KIND_READ)
                        state_next.access_kind = KIND_RMW;
                end
                MODE_IFEQUAL:
                begin
                    state_next.store_next_flag = 1'b0;
                    if (state.buffer_value != mask)
                        state_next.skip_remaining = SKIP_W'(1);
                end
                MODE_IFRANGE:
                begin
                    state_next.store_next_flag = 1'b0;
                    if (state.buffer_value < mask || state.buffer_value > value)
                        state_next.skip_remaining = SKIP_W'(1);
                end
                MODE_EQUALSKIPN:
                begin
                    state_next.store_next_flag = 1'b0;
                    if (state.buffer_value == mask)
                        state_next.skip_remaining = value[SKIP_W-1:0];
                end
                default:
                begin
                    result.action = ACT_ERROR;
                end
            endcase
        end
    end

endmodule

FILE: hdl/register_init_table_sequencer_unit.sv
`timescale 1ns / 1ps
// Top level: register-initialization table sequencer with entry and result registers.
// Each accepted table entry produces exactly one result item, held first in the entry
// register and then in the result register. The unit takes one entry per cycle:
// an entry register feeds a single pass of execution logic (mask merge, 64-bit
// base-plus-offset add, buffer compares, skip counter update) whose outcome lands
// in the result register and the running state in the same edge. The result
// register frees the entry side from output stalls; entry.ready drops only while
// both the entry register and a result item wait on result.ready. Configuration
// writes (index 0 addr_base, index 1 narrow_registers) are always taken and
// must be made while no entry is in flight. Reset leaves the buffer at zero, the
// skip counter at zero and the access kind at read-modify-write.
module register_init_table_sequencer_unit
    import rits_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rits_item_if.sink   entry,
    rits_result_if.source result,
    rits_cfg_if.sink    cfg
);

    // Entry stage
    logic       s1_valid_reg;
    item_t      s1_item_reg;
    item_t      s1_item_next;

    // Result stage
    logic       out_valid_reg;
    result_t    out_result_reg;
    result_t    exec_result;

    // Running state and configuration
    seq_state_t state_reg;
    seq_state_t state_next;
    cfg_t       cfg_reg;

    logic       out_free;
    logic       advance;
    logic       entry_take;

    // Advance the entry stage whenever the result register is empty or draining
    assign out_free    = !out_valid_reg || result.ready;
    assign advance     = s1_valid_reg && out_free;
    assign entry.ready = !s1_valid_reg || out_free;
    assign entry_take  = entry.valid && entry.ready;
    assign cfg.ready   = 1'b1;

    assign s1_item_next = '{
        mode:             entry.mode,
        entry_offset:     entry.entry_offset,
        entry_mask:       entry.entry_mask,
        entry_value:      entry.entry_value,
        current_contents: entry.current_contents
    };

    rits_exec u_exec (
        .item       (s1_item_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .result     (exec_result),
        .state_next (state_next)
    );

    // Control and running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
            cfg_reg       <= '0;
        end
        else
        begin
            if (entry.ready)
                s1_valid_reg <= entry.valid;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
            if (advance)
                state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_ADDR_BASE:        cfg_reg.addr_base        <= cfg.data;
                    CFG_NARROW_REGISTERS: cfg_reg.narrow_registers <= cfg.data[0];
                    default:              cfg_reg                  <= cfg_reg;
                endcase
            end
        end
    end

    // Payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (entry_take)
            s1_item_reg <= s1_item_next;
        if (advance)
            out_result_reg <= exec_result;
    end

    assign result.valid         = out_valid_reg;
    assign result.action        = out_result_reg.action;
    assign result.write_address = out_result_reg.write_address;
    assign result.write_data    = out_result_reg.write_data;
    assign result.delay_usec    = out_result_reg.delay_usec;
    assign result.was_skipped   = out_result_reg.was_skipped;

    // Entry side stalls only behind a blocked result
    assert property (@(posedge clk) disable iff (!rst_n)
        !entry.ready |-> (out_valid_reg && !result.ready && s1_valid_reg))
        else $error("entry stalled without output backpressure");

    // A skipped entry carries no action
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_result_reg.was_skipped) |-> (out_result_reg.action == ACT_NONE))
        else $error("skipped entry produced an action");

    // The skip counter counts down by one per consumed entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && state_reg.skip_remaining != '0 && s1_item_reg.mode != MODE_TABLESTART)
        |=> (state_reg.skip_remaining == $past(state_reg.skip_remaining) - SKIP_W'(1)))
        else $error("skip counter did not decrement");

    // Table start returns the running state to reset values
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_item_reg.mode == MODE_TABLESTART)
        |=> (state_reg == STATE_RESET))
        else $error("table start did not clear the running state");

endmodule

FILE: sim/register_init_table_sequencer_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the register-init table sequencer: directed and random entries.
module register_init_table_sequencer_unit_test;
    import rits_pkg::*;

    // Quiet cycles tolerated before the run is declared hung; the longest
    // legal quiet stretch is the deliberate result hold-off below.
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 64;
    localparam logic [WORD_W-1:0] PATTERN_A = 64'hA5A5_0F0F_C3C3_5A5A;

    logic clk;
    logic rst_n;

    rits_item_if   entry_ch ();
    rits_result_if result_ch ();
    rits_cfg_if    cfg_ch ();

    register_init_table_sequencer_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .entry  (entry_ch.sink),
        .result (result_ch.source),
        .cfg    (cfg_ch.sink)
    );

    // Shadow copy of the sequencer: running state and register values as the
    // block should hold them after every accepted entry and register write.
    seq_state_t seq_now;
    cfg_t       cfg_now;

    // Results owed by the block, oldest first.
    result_t awaited_results[$];

    int unsigned mismatches;
    bit          src_idle_on;
    bit          sink_idle_on;
    bit          hold_request;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Work out the result of one table entry and advance the shadow state.
    function automatic result_t predict_entry_result(input item_t it);
        result_t          r;
        logic [WORD_W-1:0] m;
        logic [WORD_W-1:0] v;
        logic [WORD_W-1:0] c;
        r = '0;
        m = it.entry_mask;
        v = it.entry_value;
        c = it.current_contents;
        // Narrow registers see only the low word of the mask, value and contents operands.
        if (cfg_now.narrow_registers)
        begin
            m[63:32] = '0;
            v[63:32] = '0;
            c[63:32] = '0;
        end
        if (it.mode == MODE_TABLESTART)
        begin
            // Table start wins even over a pending skip.
            seq_now = STATE_RESET;
        end
        else if (seq_now.skip_remaining != '0)
        begin
            // Consume the entry, whatever its code.
            seq_now.skip_remaining = seq_now.skip_remaining - 1;
            r.was_skipped = 1'b1;
        end
        else
        begin
            case (it.mode)
                MODE_ACCESS:
                begin
                    r.write_address = cfg_now.addr_base + {32'b0, it.entry_offset};
                    // A pending modify-store keeps the buffer as it stands.
                    if (!seq_now.store_next_flag)
                    begin
                        if (seq_now.access_kind == KIND_WRITE)
                            seq_now.buffer_value = v & ~m;
                        else
                            seq_now.buffer_value = (c & ~m) | v;
                    end
                    seq_now.store_next_flag = 1'b0;
                    if (seq_now.access_kind == KIND_READ)
                        r.action = ACT_READ;
                    else
                    begin
                        r.action = ACT_WRITE;
                        r.write_data = seq_now.buffer_value;
                        if (cfg_now.narrow_registers)
                            r.write_data[63:32] = '0;
                    end
                end
                MODE_SWITCHMODE:
                begin
                    if (m <= 64'(KIND_RMW))
                        seq_now.access_kind = kind_t'(m[1:0]);
                    else
                        r.action = ACT_ERROR;
                end
                MODE_NOP:
                begin
                end
                MODE_DELAY:
                begin
                    r.action = ACT_DELAY;
                    r.delay_usec = m[USEC_W-1:0];
                end
                MODE_MODIFYSTORE:
                begin
                    seq_now.buffer_value = (seq_now.buffer_value & ~m) | v;
                    seq_now.store_next_flag = 1'b1;
                    if (seq_now.access_kind == KIND_READ)
                        seq_now.access_kind = KIND_RMW;
                end
                MODE_IFEQUAL:
                begin
                    seq_now.store_next_flag = 1'b0;
                    if (seq_now.buffer_value != m)
                        seq_now.skip_remaining = 1;
                end
                MODE_IFRANGE:
                begin
                    seq_now.store_next_flag = 1'b0;
                    if (seq_now.buffer_value < m || seq_now.buffer_value > v)
                        seq_now.skip_remaining = 1;
                end
                MODE_EQUALSKIPN:
                begin
                    seq_now.store_next_flag = 1'b0;
                    if (seq_now.buffer_value == m)
                        seq_now.skip_remaining = v[SKIP_W-1:0];
                end
                default:
                    r.action = ACT_ERROR;
            endcase
        end
        return r;
    endfunction

    // Random word, biased toward the all-zero and all-one extremes.
    function automatic logic [WORD_W-1:0] rand_word();
        int unsigned pick;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic item_t mk_entry(input mode_t md, input logic [WORD_W-1:0] mask,
                                       input logic [WORD_W-1:0] val);
        item_t it;
        it.mode             = md;
        it.entry_offset     = OFFS_W'(rand_word());
        it.entry_mask       = mask;
        it.entry_value      = val;
        it.current_contents = rand_word();
        return it;
    endfunction

    // Pick a sensible next entry for a table in progress. Conditionals often
    // compare against the buffer as it stands so that both outcomes occur.
    function automatic item_t well_formed_entry();
        int unsigned       pick;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] w;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return mk_entry(MODE_ACCESS, rand_word(), rand_word());
        if (pick < 50)
        begin
            w = 64'($urandom_range(0, 2));
            if ($urandom_range(0, 19) == 0)
                w = rand_word();
            return mk_entry(MODE_SWITCHMODE, w, rand_word());
        end
        if (pick < 60)
            return mk_entry(MODE_MODIFYSTORE, rand_word(), rand_word());
        if (pick < 65)
            return mk_entry(MODE_NOP, rand_word(), rand_word());
        if (pick < 70)
            return mk_entry(MODE_DELAY, rand_word(), rand_word());
        if (pick < 78)
        begin
            w = $urandom_range(0, 1) ? seq_now.buffer_value : rand_word();
            return mk_entry(MODE_IFEQUAL, w, rand_word());
        end
        if (pick < 86)
        begin
            lo = seq_now.buffer_value - 64'($urandom_range(0, 3));
            hi = seq_now.buffer_value + 64'($urandom_range(0, 3));
            if ($urandom_range(0, 2) == 0)
                return mk_entry(MODE_IFRANGE, hi, lo);
            if ($urandom_range(0, 2) == 0)
                return mk_entry(MODE_IFRANGE, rand_word(), rand_word());
            return mk_entry(MODE_IFRANGE, lo, hi);
        end
        if (pick < 94)
        begin
            w = $urandom_range(0, 1) ? seq_now.buffer_value : rand_word();
            lo = {$urandom, 32'($urandom_range(0, 5))};
            if ($urandom_range(0, 24) == 0)
                lo = rand_word();
            return mk_entry(MODE_EQUALSKIPN, w, lo);
        end
        return mk_entry(mode_t'($urandom_range(9, 15)), rand_word(), rand_word());
    endfunction

    // Offer one entry, with an occasional idle burst first; hold valid high
    // afterwards so a following entry can go back to back.
    task automatic send_entry(input item_t it);
        if (src_idle_on && $urandom_range(0, 3) == 0)
        begin
            entry_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        entry_ch.valid            <= 1'b1;
        entry_ch.mode             <= it.mode;
        entry_ch.entry_offset     <= it.entry_offset;
        entry_ch.entry_mask       <= it.entry_mask;
        entry_ch.entry_value      <= it.entry_value;
        entry_ch.current_contents <= it.current_contents;
        do @(posedge clk); while (!entry_ch.ready);
        awaited_results.push_back(predict_entry_result(it));
    endtask

    // Drop the entry side and wait until every owed result has come back.
    task automatic wait_drained();
        entry_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    // Write both registers back to back; call only while the block is idle.
    task automatic load_config(input logic [WORD_W-1:0] base, input bit narrow);
        logic [WORD_W-1:0] narrow_word;
        narrow_word = {$urandom, $urandom};
        narrow_word[0] = narrow;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_ADDR_BASE;
        cfg_ch.data  <= base;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_now.addr_base = base;
        cfg_ch.index <= CFG_NARROW_REGISTERS;
        cfg_ch.data  <= narrow_word;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_now.narrow_registers = narrow_word[0];
        cfg_ch.valid <= 1'b0;
    endtask

    // Walk every code and the corner cases: reset state, store-next, each
    // access kind, bad switch operands, skip on each conditional, bad codes
    // eaten by a skip, and table start cutting a skip short.
    task automatic test_directed_entries();
        item_t it;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        load_config('0, 1'b0);
        // Reset state is read-modify-write; use all-one fields.
        it = mk_entry(MODE_ACCESS, '0, '1);
        it.entry_offset = '1;
        it.current_contents = '1;
        send_entry(it);
        it = mk_entry(MODE_ACCESS, '1, '0);
        it.entry_offset = '0;
        send_entry(it);
        send_entry(mk_entry(MODE_TABLESTART, '1, '1));
        send_entry(mk_entry(MODE_SWITCHMODE, 64'(KIND_READ), '1));
        send_entry(mk_entry(MODE_ACCESS, rand_word(), rand_word()));
        // Modify-store in read mode turns the kind into read-modify-write.
        send_entry(mk_entry(MODE_MODIFYSTORE, '1, 64'h1234));
        send_entry(mk_entry(MODE_ACCESS, rand_word(), rand_word()));
        send_entry(mk_entry(MODE_SWITCHMODE, 64'(KIND_WRITE), '0));
        send_entry(mk_entry(MODE_ACCESS, 64'hF0, 64'hFF));
        send_entry(mk_entry(MODE_SWITCHMODE, 64'd3, '0));
        send_entry(mk_entry(MODE_SWITCHMODE, 64'hFFFF_FFFF_0000_0001, '0));
        send_entry(mk_entry(MODE_NOP, '1, '1));
        send_entry(mk_entry(MODE_DELAY, '1, '0));
        send_entry(mk_entry(MODE_DELAY, 64'hDEAD_BEEF_0000_0005, '1));
        // Load a known buffer, then take both branches of each conditional.
        send_entry(mk_entry(MODE_MODIFYSTORE, '1, PATTERN_A));
        send_entry(mk_entry(MODE_IFEQUAL, PATTERN_A, '0));
        send_entry(mk_entry(MODE_IFEQUAL, ~PATTERN_A, '0));
        send_entry(mk_entry(MODE_ACCESS, rand_word(), rand_word()));
        send_entry(mk_entry(MODE_IFRANGE, PATTERN_A, PATTERN_A));
        send_entry(mk_entry(MODE_IFRANGE, PATTERN_A + 1, '1));
        send_entry(mk_entry(MODE_NOP, '0, '0));
        send_entry(mk_entry(MODE_EQUALSKIPN, PATTERN_A, 64'hFFFF_FFFF_0000_0003));
        send_entry(mk_entry(mode_t'(9), rand_word(), rand_word()));
        send_entry(mk_entry(mode_t'(15), rand_word(), rand_word()));
        send_entry(mk_entry(MODE_TABLESTART, '0, '0));
        send_entry(mk_entry(mode_t'(9), '0, '0));
        send_entry(mk_entry(mode_t'(15), '1, '1));
        wait_drained();
    endtask

    // Mostly well-formed tables with random content, plus raw noise runs.
    task automatic test_random_tables(input logic [WORD_W-1:0] base, input bit narrow,
                                      input int unsigned entry_budget, input bit idling);
        int unsigned sent;
        int unsigned span;
        load_config(base, narrow);
        sent = 0;
        while (sent < entry_budget)
        begin
            src_idle_on  = idling && ($urandom_range(0, 2) != 0);
            sink_idle_on = idling && ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 4) == 0)
            begin
                span = $urandom_range(2, 8);
                repeat (span)
                    send_entry(mk_entry(mode_t'($urandom_range(0, 15)), rand_word(),
                                        rand_word()));
            end
            else
            begin
                send_entry(mk_entry(MODE_TABLESTART, rand_word(), rand_word()));
                span = $urandom_range(4, 24);
                repeat (span)
                    send_entry(well_formed_entry());
                span = span + 1;
            end
            sent = sent + span;
        end
        wait_drained();
    endtask

    // Hold the result side off for a long stretch while entries keep coming,
    // so the block fills and must stall its entry side.
    task automatic test_result_backpressure();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        hold_request = 1'b1;
        send_entry(mk_entry(MODE_TABLESTART, '0, '0));
        repeat (40)
            send_entry(well_formed_entry());
        wait_drained();
    endtask

    // Result side: random stall bursts, or one long counted hold-off.
    initial
    begin : result_drain
        int unsigned stall_left;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && sink_idle_on && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 7);
            if (stall_left != 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left = stall_left - 1;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    task automatic report_result_error(input string what, input result_t want,
                                       input result_t got);
        mismatches = mismatches + 1;
        if (mismatches <= 10)
        begin
            $display("%0t %s", $realtime, what);
            $display("  expected act=%0d addr=%h data=%h usec=%h skip=%b",
                     want.action, want.write_address, want.write_data,
                     want.delay_usec, want.was_skipped);
            $display("  actual   act=%0d addr=%h data=%h usec=%h skip=%b",
                     got.action, got.write_address, got.write_data,
                     got.delay_usec, got.was_skipped);
        end
    endtask

    // Compare every accepted result with the oldest one owed.
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.action        = result_ch.action;
            got.write_address = result_ch.write_address;
            got.write_data    = result_ch.write_data;
            got.delay_usec    = result_ch.delay_usec;
            got.was_skipped   = result_ch.was_skipped;
            if (awaited_results.size() == 0)
                report_result_error("unexpected result", '0, got);
            else
            begin
                want = awaited_results.pop_front();
                if (got !== want)
                    report_result_error("result mismatch", want, got);
            end
        end
    end

    // End the run if nothing moves on any channel for too long.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((entry_ch.valid && entry_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet = quiet + 1;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : run_tests
        mismatches   = 0;
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        hold_request = 1'b0;
        seq_now      = STATE_RESET;
        cfg_now      = '0;
        // Drive every input known from time zero and hold reset.
        rst_n                     <= 1'b0;
        entry_ch.valid            <= 1'b0;
        entry_ch.mode             <= MODE_NOP;
        entry_ch.entry_offset     <= '0;
        entry_ch.entry_mask       <= '0;
        entry_ch.entry_value      <= '0;
        entry_ch.current_contents <= '0;
        cfg_ch.valid              <= 1'b0;
        cfg_ch.index              <= CFG_ADDR_BASE;
        cfg_ch.data               <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_entries();
        test_random_tables('0, 1'b0, 180, 1'b1);
        // All-one base makes every address with a nonzero offset wrap.
        test_random_tables('1, 1'b1, 180, 1'b1);
        test_random_tables({$urandom, $urandom}, 1'b0, 160, 1'b1);
        test_result_backpressure();
        // Close with a stretch of back-to-back traffic, no idling at all.
        test_random_tables({$urandom, $urandom}, 1'b1, 150, 1'b0);

        // Let any stray result show up before the verdict.
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
